// ----- sv/diagonal_kalman_filter_update_defines.svh -----
// assertion macros used by the filter top module
`ifndef DIAGONAL_KALMAN_FILTER_UPDATE_DEFINES_SVH
`define DIAGONAL_KALMAN_FILTER_UPDATE_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define DKFU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
// next-cycle implication
`define DKFU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define DKFU_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DKFU_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/dkfu_pkg.sv -----
package dkfu_pkg;

    // fixed-point layout
    localparam int FRAC_BITS   = 16;
    localparam int VAR_W       = FRAC_BITS + 2;
    localparam int DEN_W       = VAR_W + 1;
    localparam int K_W         = FRAC_BITS;
    localparam int Q_W         = FRAC_BITS + 1;
    localparam int XW          = 32;
    localparam int DIFF_W      = XW + 1;
    localparam int TOT_W       = 40;
    localparam int REM_W       = VAR_W + 2;
    localparam int DIV_CNT_W   = $clog2(FRAC_BITS + 1);

    // shared multiplier operands
    localparam int MUL_A_W     = FRAC_BITS + 1;
    localparam int MUL_B_W     = DIFF_W;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

    localparam int MAX_DIM_DEF = 16;

    // register file
    localparam int NUM_CFG     = 4;
    localparam int CFG_ADDR_W  = $clog2(4 * NUM_CFG);
    localparam int CFG_DATA_W  = 32;

    localparam logic [VAR_W-1:0] ONE_FX   = VAR_W'(1) << FRAC_BITS;
    localparam logic [VAR_W-1:0] HALF_FX  = ONE_FX >> 1;
    localparam logic [VAR_W-1:0] VAR_MAX  = '1;
    localparam logic [K_W-1:0]   K_MAX    = '1;

    typedef enum logic [1:0] {
        REG_DIM    = 2'd0,
        REG_PNOISE = 2'd1,
        REG_MNOISE = 2'd2,
        REG_IVAR   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- sv/dkfu_div.sv -----
module dkfu_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [dkfu_pkg::VAR_W-1:0]  num,
    input  logic [dkfu_pkg::DEN_W-1:0]  den,
    output dkfu_pkg::div_stat_t         stat,
    output logic [dkfu_pkg::Q_W-1:0]    quot
);
    import dkfu_pkg::*;

    // restoring divider, one quotient bit per cycle, num*2^F / den
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [DEN_W-1:0]     den_reg, den_next;
    logic [Q_W-1:0]       quot_reg, quot_next;
    logic                 ge;
    logic [REM_W-1:0]     rem_sub;

    assign ge      = rem_reg >= REM_W'(den_reg);
    assign rem_sub = ge ? (rem_reg - REM_W'(den_reg)) : rem_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(FRAC_BITS);
            rem_next  = REM_W'(num);
            den_next  = den;
            quot_next = '0;
        end else if (busy_reg) begin
            quot_next = {quot_reg[Q_W-2:0], ge};
            rem_next  = {rem_sub[REM_W-2:0], 1'b0};
            cnt_next  = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quot_reg;

endmodule

// ----- sv/dkfu_mul.sv -----
module dkfu_mul (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [dkfu_pkg::MUL_A_W-1:0]  op_a,
    input  logic [dkfu_pkg::MUL_B_W-1:0]  op_b,
    output logic [dkfu_pkg::MUL_P_W-1:0]  prod
);
    import dkfu_pkg::*;

    // unsigned multiply, product registered
    logic [MUL_P_W-1:0] prod_reg, prod_next;

    assign prod_next = MUL_P_W'(op_a) * MUL_P_W'(op_b);

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// ----- sv/diagonal_kalman_filter_update.sv -----
// a new measurement request is accepted only in ST_IDLE, once the last element is written back to m_*
// each element runs through the 17-step serial divider that forms the gain k, followed by two passes
//   through the one shared multiplier
// a restart request gives no result
// reset (aresetn, synchronous, active low) loads default registers, clears estimates and
//   the running total at once through per-element valid bits; no clearing pass
`include "diagonal_kalman_filter_update_defines.svh"
module diagonal_kalman_filter_update #(
    parameter int MAX_DIM = dkfu_pkg::MAX_DIM_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // configuration port
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [dkfu_pkg::CFG_ADDR_W-1:0]         paddr,
    input  logic [dkfu_pkg::CFG_DATA_W-1:0]         pwdata,
    output logic [dkfu_pkg::CFG_DATA_W-1:0]         prdata,
    output logic                                    pready,
    // input requests
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic                                    s_action,
    input  logic signed [dkfu_pkg::XW-1:0]          s_measurement,
    input  logic                                    s_last_of_run,
    // result requests
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] m_element_index,
    output logic signed [dkfu_pkg::XW-1:0]          m_estimate,
    output logic                                    m_sum_valid,
    output logic signed [dkfu_pkg::TOT_W-1:0]       m_total_estimate
);
    import dkfu_pkg::*;

    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int XS_W  = MUL_P_W - FRAC_BITS + 2;   // estimate plus correction
    localparam int DX_W  = XW + 2;                    // change of one estimate
    localparam int TS_W  = TOT_W + 1;                 // total plus change

    // sequencer states
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_LOAD = 6'b000010,
        ST_DIV  = 6'b000100,
        ST_MULA = 6'b001000,
        ST_MULB = 6'b010000,
        ST_UPD  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [DIM_W-1:0] dim_cfg_reg, dim_cfg_next;
    logic [VAR_W-1:0] pnoise_reg, pnoise_next;
    logic [VAR_W-1:0] mnoise_reg, mnoise_next;
    logic [VAR_W-1:0] ivar_reg, ivar_next;

    // filter state
    logic [VAR_W-1:0]        rst_var_reg, rst_var_next;     // variance loaded at last restart
    logic [IDX_W-1:0]        next_elem_reg, next_elem_next;
    logic signed [TOT_W-1:0] total_reg, total_next;
    logic [MAX_DIM-1:0]      ent_valid_reg, ent_valid_next; // entry written since restart

    // per-element storage, read data registered
    logic signed [XW-1:0] est_mem [MAX_DIM];
    logic [VAR_W-1:0]     var_mem [MAX_DIM];
    logic signed [XW-1:0] est_rd_reg;
    logic [VAR_W-1:0]     var_rd_reg;
    logic                 rd_valid_reg;

    // working registers of one element
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic signed [XW-1:0]     z_reg, z_next;
    logic                     last_reg, last_next;
    logic signed [XW-1:0]     x_reg, x_next;
    logic [VAR_W-1:0]         p1_reg, p1_next;
    logic                     den_zero_reg, den_zero_next;
    logic signed [DIFF_W-1:0] diff_reg, diff_next;
    logic [K_W-1:0]           k_reg, k_next;
    logic signed [XW-1:0]     xnew_reg, xnew_next;

    // output register
    logic                    m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]        m_idx_reg, m_idx_next;
    logic signed [XW-1:0]    m_est_reg, m_est_next;
    logic                    m_sumv_reg, m_sumv_next;
    logic signed [TOT_W-1:0] m_tot_reg, m_tot_next;

    // shared units
    div_stat_t          div_stat;
    logic [Q_W-1:0]     div_quot;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_prod;
    logic               mul_en;

    // combinational helpers
    logic                     cfg_wr;
    cfg_reg_t                 cfg_sel;
    logic [DIM_W-1:0]         dim_act;
    logic [IDX_W-1:0]         idx_sel;
    logic                     meas_acc;
    logic                     rst_acc;
    logic signed [XW-1:0]     x_cur;
    logic [VAR_W-1:0]         p_cur;
    logic [VAR_W:0]           p_sum;
    logic [VAR_W-1:0]         p1_calc;
    logic [DEN_W-1:0]         den_calc;
    logic signed [DIFF_W-1:0] diff_calc;
    logic [MUL_B_W-1:0]       abs_diff;
    logic [MUL_P_W:0]         prod_rnd;
    logic [XS_W-2:0]          corr_mag;
    logic signed [XS_W-1:0]   x_sum;
    logic signed [XW-1:0]     x_sat;
    logic [VAR_W-1:0]         pnew;
    logic signed [DX_W-1:0]   dx;
    logic signed [TS_W-1:0]   t_sum;
    logic signed [TOT_W-1:0]  t_sat;
    logic                     last_elem;
    logic                     upd_fire;

    // register access, pready tied high
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);

    always_comb begin
        case (cfg_sel)
            REG_DIM:    prdata = CFG_DATA_W'(dim_cfg_reg);
            REG_PNOISE: prdata = CFG_DATA_W'(pnoise_reg);
            REG_MNOISE: prdata = CFG_DATA_W'(mnoise_reg);
            REG_IVAR:   prdata = CFG_DATA_W'(ivar_reg);
            default:    prdata = '0;
        endcase
    end

    // dimension of zero acts as one, above MAX_DIM acts as MAX_DIM
    always_comb begin
        if (dim_cfg_reg == '0) begin
            dim_act = DIM_W'(1);
        end else if (dim_cfg_reg > DIM_W'(MAX_DIM)) begin
            dim_act = DIM_W'(MAX_DIM);
        end else begin
            dim_act = dim_cfg_reg;
        end
    end

    // element pointer wraps to zero if the dimension shrank under it
    assign idx_sel  = (DIM_W'(next_elem_reg) >= dim_act) ? '0 : next_elem_reg;
    assign s_ready  = (state_reg == ST_IDLE);
    assign meas_acc = s_valid && s_ready && s_action;
    assign rst_acc  = s_valid && s_ready && !s_action;

    // entries not written since restart read as zero estimate and restart variance
    assign x_cur     = rd_valid_reg ? est_rd_reg : '0;
    assign p_cur     = rd_valid_reg ? var_rd_reg : rst_var_reg;
    assign p_sum     = {1'b0, p_cur} + {1'b0, pnoise_reg};
    assign p1_calc   = p_sum[VAR_W] ? VAR_MAX : p_sum[VAR_W-1:0];
    assign den_calc  = {1'b0, p1_calc} + {1'b0, mnoise_reg};
    assign diff_calc = {z_reg[XW-1], z_reg} - {x_cur[XW-1], x_cur};
    assign abs_diff  = diff_reg[DIFF_W-1] ? MUL_B_W'(-diff_reg) : MUL_B_W'(diff_reg);

    // multiplier: k*|z-x| in first pass, (1-k)*p1 in second
    assign mul_en = (state_reg == ST_MULA) || (state_reg == ST_MULB);
    assign mul_a  = (state_reg == ST_MULB) ? (MUL_A_W'(ONE_FX) - {1'b0, k_reg})
                                           : {1'b0, k_reg};
    assign mul_b  = (state_reg == ST_MULB) ? MUL_B_W'(p1_reg) : abs_diff;

    // correction floors toward minus infinity: a negative difference rounds its
    // magnitude up
    assign prod_rnd = {1'b0, mul_prod} + (MUL_P_W + 1)'(ONE_FX - VAR_W'(1));
    assign corr_mag = diff_reg[DIFF_W-1] ? prod_rnd[MUL_P_W:FRAC_BITS]
                                         : {1'b0, mul_prod[MUL_P_W-1:FRAC_BITS]};
    assign x_sum    = diff_reg[DIFF_W-1]
                    ? (XS_W'(x_reg) - $signed({1'b0, corr_mag}))
                    : (XS_W'(x_reg) + $signed({1'b0, corr_mag}));

    // saturate the new estimate to 32 bits
    always_comb begin
        if (x_sum[XS_W-1:XW-1] == '0 || x_sum[XS_W-1:XW-1] == '1) begin
            x_sat = x_sum[XW-1:0];
        end else if (x_sum[XS_W-1]) begin
            x_sat = {1'b1, {(XW-1){1'b0}}};
        end else begin
            x_sat = {1'b0, {(XW-1){1'b1}}};
        end
    end

    // new variance from second multiplier pass, truncated and saturated
    assign pnew = (|mul_prod[MUL_P_W-1:FRAC_BITS+VAR_W]) ? VAR_MAX
                : mul_prod[FRAC_BITS+VAR_W-1:FRAC_BITS];

    // running total follows the change of this estimate
    assign dx    = DX_W'(xnew_reg) - DX_W'(x_reg);
    assign t_sum = TS_W'(total_reg) + TS_W'(dx);
    always_comb begin
        if (t_sum[TS_W-1] == t_sum[TOT_W-1]) begin
            t_sat = t_sum[TOT_W-1:0];
        end else if (t_sum[TS_W-1]) begin
            t_sat = {1'b1, {(TOT_W-1){1'b0}}};
        end else begin
            t_sat = {1'b0, {(TOT_W-1){1'b1}}};
        end
    end

    assign last_elem = (DIM_W'(idx_reg) + DIM_W'(1)) == dim_act;
    // write-back waits for the output register to be free
    assign upd_fire  = (state_reg == ST_UPD) && (!m_valid_reg || m_ready);

    dkfu_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == ST_LOAD),
        .num     (p1_calc),
        .den     (den_calc),
        .stat    (div_stat),
        .quot    (div_quot)
    );

    dkfu_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_prod)
    );

    // sequencer and next-state logic
    always_comb begin
        state_next     = state_reg;
        dim_cfg_next   = dim_cfg_reg;
        pnoise_next    = pnoise_reg;
        mnoise_next    = mnoise_reg;
        ivar_next      = ivar_reg;
        rst_var_next   = rst_var_reg;
        next_elem_next = next_elem_reg;
        total_next     = total_reg;
        ent_valid_next = ent_valid_reg;
        idx_next       = idx_reg;
        z_next         = z_reg;
        last_next      = last_reg;
        x_next         = x_reg;
        p1_next        = p1_reg;
        den_zero_next  = den_zero_reg;
        diff_next      = diff_reg;
        k_next         = k_reg;
        xnew_next      = xnew_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_idx_next     = m_idx_reg;
        m_est_next     = m_est_reg;
        m_sumv_next    = m_sumv_reg;
        m_tot_next     = m_tot_reg;

        // register writes
        if (cfg_wr) begin
            case (cfg_sel)
                REG_DIM:    dim_cfg_next = pwdata[DIM_W-1:0];
                REG_PNOISE: pnoise_next  = pwdata[VAR_W-1:0];
                REG_MNOISE: mnoise_next  = pwdata[VAR_W-1:0];
                REG_IVAR:   ivar_next    = pwdata[VAR_W-1:0];
                default:    ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (meas_acc) begin
                    idx_next   = idx_sel;
                    z_next     = s_measurement;
                    last_next  = s_last_of_run;
                    state_next = ST_LOAD;
                end else if (rst_acc) begin
                    // restart: drop all entries, latch the variance to reload
                    ent_valid_next = '0;
                    total_next     = '0;
                    next_elem_next = '0;
                    rst_var_next   = ivar_reg;
                end
            end
            ST_LOAD: begin
                // predicted variance and innovation; divider starts this cycle
                x_next        = x_cur;
                p1_next       = p1_calc;
                den_zero_next = (den_calc == '0);
                diff_next     = diff_calc;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    // zero denominator gives zero gain; a gain of one does not fit and saturates
                    if (den_zero_reg) begin
                        k_next = '0;
                    end else if (div_quot[Q_W-1]) begin
                        k_next = K_MAX;
                    end else begin
                        k_next = div_quot[K_W-1:0];
                    end
                    state_next = ST_MULA;
                end
            end
            ST_MULA: begin
                state_next = ST_MULB;
            end
            ST_MULB: begin
                xnew_next  = x_sat;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (upd_fire) begin
                    ent_valid_next[idx_reg] = 1'b1;
                    total_next     = t_sat;
                    next_elem_next = last_elem ? '0 : (idx_reg + IDX_W'(1));
                    m_valid_next   = 1'b1;
                    m_idx_next     = idx_reg;
                    m_est_next     = xnew_reg;
                    m_sumv_next    = last_elem && last_reg;
                    m_tot_next     = (last_elem && last_reg) ? t_sat : '0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            dim_cfg_reg   <= DIM_W'(MAX_DIM);
            pnoise_reg    <= HALF_FX;
            mnoise_reg    <= HALF_FX;
            ivar_reg      <= ONE_FX;
            rst_var_reg   <= ONE_FX;
            next_elem_reg <= '0;
            total_reg     <= '0;
            ent_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            dim_cfg_reg   <= dim_cfg_next;
            pnoise_reg    <= pnoise_next;
            mnoise_reg    <= mnoise_next;
            ivar_reg      <= ivar_next;
            rst_var_reg   <= rst_var_next;
            next_elem_reg <= next_elem_next;
            total_reg     <= total_next;
            ent_valid_reg <= ent_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        z_reg        <= z_next;
        last_reg     <= last_next;
        x_reg        <= x_next;
        p1_reg       <= p1_next;
        den_zero_reg <= den_zero_next;
        diff_reg     <= diff_next;
        k_reg        <= k_next;
        xnew_reg     <= xnew_next;
        m_idx_reg    <= m_idx_next;
        m_est_reg    <= m_est_next;
        m_sumv_reg   <= m_sumv_next;
        m_tot_reg    <= m_tot_next;
    end

    // element storage: read on accept, write on update
    always_ff @(posedge aclk) begin
        if (upd_fire) begin
            est_mem[idx_reg] <= xnew_reg;
            var_mem[idx_reg] <= pnew;
        end
        if (meas_acc) begin
            est_rd_reg   <= est_mem[idx_sel];
            var_rd_reg   <= var_mem[idx_sel];
            rd_valid_reg <= ent_valid_reg[idx_sel];
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_element_index  = m_idx_reg;
    assign m_estimate       = m_est_reg;
    assign m_sum_valid      = m_sumv_reg;
    assign m_total_estimate = m_tot_reg;

    // divider only runs while the sequencer waits on it
    `DKFU_ASSERT_IMP(a_div_owned, aclk, aresetn, div_stat.busy || div_stat.done, state_reg == ST_DIV)
    // total is only shown with the final sum
    `DKFU_ASSERT_IMP(a_total_gated, aclk, aresetn, m_valid && !m_sum_valid, m_total_estimate == '0)
    // a stalled output keeps the write-back waiting
    `DKFU_ASSERT_NXT(a_upd_stall, aclk, aresetn, (state_reg == ST_UPD) && m_valid && !m_ready, state_reg == ST_UPD)
    // restart clears entries, total and pointer
    `DKFU_ASSERT_NXT(a_restart, aclk, aresetn, rst_acc, (ent_valid_reg == '0) && (total_reg == '0) && (next_elem_reg == '0))
    // a measurement starts the element sequence
    `DKFU_ASSERT_NXT(a_meas_start, aclk, aresetn, meas_acc, state_reg == ST_LOAD)

endmodule
